// ===== design/frc_pkg.sv =====
// Shared types, command codes and CRC-32 constants for the frame CRC recorder.
// Depends on nothing; every other file in the design imports it.
package frc_pkg;

    // Reflected CRC-32 (IEEE 802.3) polynomial and start value.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Command codes carried in the input tuser field.
    typedef enum logic [2:0] {
        CMD_PIXEL     = 3'd0,
        CMD_FRAME_END = 3'd1,
        CMD_READ      = 3'd2,
        CMD_CLEAR     = 3'd3,
        CMD_RESTART   = 3'd4
    } t_cmd;

    // One stored frame record, 192 bits.
    typedef struct packed {
        logic [31:0] crc;
        logic [15:0] height;
        logic [15:0] width;
        logic [63:0] src_frame_no;
        logic [63:0] out_frame_no;
    } t_record;

    // Control from the pipeline to the CRC accumulator.
    typedef struct packed {
        logic fold;
        logic restart;
    } t_crc_ctrl;

    typedef logic [31:0][31:0] t_crc_cols;

    // Folding 32 bits through the CRC is linear, so each input bit maps to a
    // fixed output column. This is evaluated once, at elaboration.
    function automatic t_crc_cols crc_columns();
        t_crc_cols   cols;
        logic [31:0] v;
        for (int j = 0; j < 32; j++) begin
            v = 32'h1 << j;
            for (int k = 0; k < 32; k++) begin
                v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'h0);
            end
            cols[j] = v;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_columns();

endpackage

// ===== design/frame_crc_capture_recorder.sv =====
// Top level of the frame CRC recorder: input register, command decode,
// result register. Depends on frc_pkg, frc_crc_unit and frc_record_store.
//
// Takes one transfer per cycle of any command while the result register is
// free or being taken, and passes it through the single decode stage between
// the input register and the result register, with the record memory read
// there and its registered output feeding the result. Pixel words fold 32 bits
// into the CRC through a combinational column XOR. Clear-all and restart-count
// both simply zero the record count: a read only returns slots below the count,
// which were always written since, so no clearing pass of the memory is needed
// and the block is ready straight out of reset.
module frame_crc_capture_recorder #(
    parameter int RECORDS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // s_tdata, lowest bit up: pixel_word[31:0], out_frame_no[63:0],
    // src_frame_no[63:0], frame_width[15:0], frame_height[15:0], record_slot[7:0]
    input  logic [199:0] s_tdata,
    // s_tuser: cmd[2:0]
    input  logic [2:0]   s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_tdata, lowest bit up: rec_out_frame_no[63:0], rec_src_frame_no[63:0],
    // rec_width[15:0], rec_height[15:0], rec_crc[31:0], rec_in_range,
    // record_count[8:0], dropped, then five zero bits
    output logic [207:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready
);
    import frc_pkg::*;

    localparam int ADDR_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CNT_W  = $clog2(RECORDS + 1);

    // Input register.
    logic         r_v1;
    logic [2:0]   r_cmd;
    logic [199:0] r_data;

    // Result register.
    logic         r_v2;
    logic         r_use_mem;
    t_record      r_rec;
    logic         r_in_range;
    logic [8:0]   r_count_out;
    logic         r_dropped;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             w_en2;
    logic             w_fire1;
    logic [31:0]      w_crc;
    t_crc_ctrl        w_crc_ctrl;
    t_record          w_new_rec;
    t_record          w_rd_rec;
    logic             w_full;
    logic             w_wr_en;
    logic             w_rd_en;
    logic             w_hit;
    logic [CNT_W+7:0] w_slot_ext;
    logic [CNT_W+7:0] w_cnt_ext;
    logic [CNT_W+8:0] w_cnt_wide;
    logic             n_has_result;
    logic             n_use_mem;
    t_record          n_rec;
    logic             n_in_range;
    logic             n_dropped;
    t_record          w_out_rec;

    // Handshake: the result register frees when empty or taken.
    assign w_en2    = !r_v2 || m_tready;
    assign w_fire1  = r_v1 && w_en2;
    assign s_tready = !r_v1 || w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_tready) begin
            r_v1 <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_cmd  <= s_tuser;
            r_data <= s_tdata;
        end
    end

    // Record built from the current transfer and the finished CRC.
    always_comb begin
        w_new_rec.out_frame_no = r_data[95:32];
        w_new_rec.src_frame_no = r_data[159:96];
        w_new_rec.width        = r_data[175:160];
        w_new_rec.height       = r_data[191:176];
        w_new_rec.crc          = w_crc ^ CRC_INIT;
    end

    assign w_full     = (r_count == CNT_W'(RECORDS));
    assign w_slot_ext = {{CNT_W{1'b0}}, r_data[199:192]};
    assign w_cnt_ext  = {8'h00, r_count};
    assign w_hit      = (w_slot_ext < w_cnt_ext);

    // Command decode and state updates.
    always_comb begin
        w_crc_ctrl   = '0;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;
        n_count      = r_count;
        n_has_result = 1'b0;
        n_use_mem    = 1'b0;
        n_rec        = '0;
        n_in_range   = 1'b0;
        n_dropped    = 1'b0;
        if (w_fire1) begin
            unique case (r_cmd) inside
                CMD_PIXEL: begin
                    w_crc_ctrl.fold = 1'b1;
                end
                CMD_FRAME_END: begin
                    w_crc_ctrl.restart = 1'b1;
                    n_has_result       = 1'b1;
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        w_wr_en    = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                        n_rec      = w_new_rec;
                        n_in_range = 1'b1;
                    end
                end
                CMD_READ: begin
                    n_has_result = 1'b1;
                    w_rd_en      = w_hit;
                    n_use_mem    = w_hit;
                    n_in_range   = w_hit;
                end
                CMD_CLEAR, CMD_RESTART: begin
                    n_has_result = 1'b1;
                    n_count      = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    frc_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_crc_ctrl),
        .i_word  (r_data[31:0]),
        .o_crc   (w_crc)
    );

    frc_record_store #(
        .DEPTH  (RECORDS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_rec  (w_new_rec),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_slot_ext[ADDR_W-1:0]),
        .o_rd_rec  (w_rd_rec)
    );

    // Count reported modulo 512.
    assign w_cnt_wide = {9'h000, n_count};

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= n_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_use_mem   <= n_use_mem;
            r_rec       <= n_rec;
            r_in_range  <= n_in_range;
            r_count_out <= w_cnt_wide[8:0];
            r_dropped   <= n_dropped;
        end
    end

    // A read hit takes its fields from the memory's read register.
    assign w_out_rec = r_use_mem ? w_rd_rec : r_rec;

    assign m_tvalid = r_v2;
    assign m_tdata  = {5'b0_0000, r_dropped, r_count_out, r_in_range,
                       w_out_rec.crc, w_out_rec.height, w_out_rec.width,
                       w_out_rec.src_frame_no, w_out_rec.out_frame_no};

endmodule

// ===== design/frc_crc_unit.sv =====
// Running CRC-32 accumulator with a combinational 32-bit fold per word.
// Depends on frc_pkg for the column table and control struct.
module frc_crc_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frc_pkg::t_crc_ctrl i_ctrl,
    input  logic [31:0]        i_word,
    output logic [31:0]        o_crc
);
    import frc_pkg::*;

    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [31:0] w_x;
    logic [31:0] w_fold;

    // XOR of the columns selected by the bits of accumulator ^ word.
    always_comb begin
        w_x    = r_acc ^ i_word;
        w_fold = 32'h0;
        for (int j = 0; j < 32; j++) begin
            if (w_x[j]) begin
                w_fold = w_fold ^ CRC_COLS[j];
            end
        end
    end

    // Restart has priority; the pipeline never asks for both at once.
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.restart) begin
            n_acc = CRC_INIT;
        end else if (i_ctrl.fold) begin
            n_acc = w_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= CRC_INIT;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_crc = r_acc;

endmodule

// ===== design/frc_record_store.sv =====
// Record memory: one write port and one registered read port.
// Depends on frc_pkg for the record type.
module frc_record_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  frc_pkg::t_record     i_wr_rec,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output frc_pkg::t_record     o_rd_rec
);
    import frc_pkg::*;

    t_record r_mem [DEPTH];
    t_record r_rd_rec;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_rec;
        end
    end

    // Read data holds between reads so a stalled result stays put.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_rec <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_rec = r_rd_rec;

endmodule
